@@ sv/rspu_pkg.sv @@
// Shared constants and types for the ranked slice prune/unprune block.
`default_nettype none

package rspu_pkg;

  // Default sizes of the element fields and of the rank stack
  localparam int unsigned SetBitsDef    = 32;
  localparam int unsigned RankBitsDef   = 8;
  localparam int unsigned StackDepthDef = 32;

  // Entries in the queue between the front and the back
  localparam int unsigned InQueueDepth  = 2;

  // Stack engine states
  typedef enum logic [0:0] {
    BK_IDLE,
    BK_CMP
  } back_state_e;

endpackage

`default_nettype wire

@@ sv/rspu_front.sv @@
// Input side: accepts element beats and holds them in a short queue for the stack engine.
`default_nettype none

module rspu_front #(
  parameter int unsigned DataW = 41
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [DataW-1:0] wdata_i,
  output logic                  valid_o,
  output logic [DataW-1:0]      rdata_o,
  input  wire logic             ready_i
);
  import rspu_pkg::*;

  localparam int unsigned PtrW = (InQueueDepth > 1) ? $clog2(InQueueDepth) : 1;
  localparam int unsigned CntW = $clog2(InQueueDepth + 1);

  logic [DataW-1:0] slot_q [InQueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full    = (cnt_q == CntW'(InQueueDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign wr_en   = push & ~full;
  assign rd_en   = valid_o & ready_i;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(InQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(InQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/rspu_back.sv @@
// Stack engine: pops higher-ranked entries, converts the set, pushes unless full and emits one result.
`default_nettype none

module rspu_back #(
  parameter int unsigned SetBits    = 32,
  parameter int unsigned RankBits   = 8,
  parameter int unsigned StackDepth = 32,
  localparam int unsigned CntW      = $clog2(StackDepth + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                prune_mode_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SetBits-1:0]  in_set_i,
  input  wire logic [RankBits-1:0] in_rank_i,
  input  wire logic                in_last_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [SetBits-1:0]       out_set_o,
  output logic [RankBits-1:0]      out_rank_o,
  output logic                     out_last_o,
  output logic                     overflow_o,
  output logic [CntW-1:0]          stk_cnt_o
);
  import rspu_pkg::*;

  localparam int unsigned IdxW = $clog2(StackDepth);
  localparam int unsigned EntW = SetBits + RankBits;

  back_state_e state_q, state_d;

  // Stack storage, one set/rank pair per entry
  logic [EntW-1:0]     mem [StackDepth];
  logic [EntW-1:0]     rd_q;
  logic [SetBits-1:0]  rd_set;
  logic [RankBits-1:0] rd_rank;

  logic [CntW-1:0]     cnt_q, cnt_d, cnt_n;
  logic [SetBits-1:0]  set_q, acc_q, acc_d, acc_n, merged;
  logic [RankBits-1:0] rank_q;
  logic                last_q;
  logic                latch;
  logic                pop_hit, done, stk_full;

  logic                rd_en, wr_en;
  logic [CntW-1:0]     rd_ptr, wr_ptr;
  logic [EntW-1:0]     wr_data;

  logic                out_valid_q, out_space;
  logic                emit;
  logic [SetBits-1:0]  emit_set;
  logic [RankBits-1:0] emit_rank;
  logic                emit_last, emit_ovf;

  assign rd_set    = rd_q[EntW-1:RankBits];
  assign rd_rank   = rd_q[RankBits-1:0];
  assign out_space = ~out_valid_q | pop;
  assign empty     = ~out_valid_q;
  assign stk_cnt_o = cnt_q;

  // Pop test against the top entry and the set conversion
  assign merged   = prune_mode_i ? (acc_q & ~rd_set) : (acc_q | rd_set);
  assign pop_hit  = (rank_q < rd_rank);
  assign acc_n    = pop_hit ? merged : acc_q;
  assign cnt_n    = cnt_q - {{(CntW-1){1'b0}}, pop_hit};
  assign done     = ~pop_hit | (cnt_n == '0);
  assign stk_full = (cnt_n == CntW'(StackDepth));

  // Sequence one element: read top, pop while ranked higher, then push and emit
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    latch      = 1'b0;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_ptr     = '0;
    wr_en      = 1'b0;
    wr_ptr     = '0;
    wr_data    = {in_set_i, in_rank_i};
    emit       = 1'b0;
    emit_set   = in_set_i;
    emit_rank  = in_rank_i;
    emit_last  = in_last_i;
    emit_ovf   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (in_valid_i) begin
          if (cnt_q != '0) begin
            in_ready_o = 1'b1;
            latch      = 1'b1;
            acc_d      = in_set_i;
            rd_en      = 1'b1;
            rd_ptr     = cnt_q - 1'b1;
            state_d    = BK_CMP;
          end else if (out_space) begin
            // Empty stack: nothing to pop, push and emit at once
            in_ready_o = 1'b1;
            emit       = 1'b1;
            wr_en      = 1'b1;
            wr_ptr     = '0;
            cnt_d      = in_last_i ? '0 : CntW'(1);
          end
        end
      end
      BK_CMP: begin
        if (!done) begin
          acc_d  = acc_n;
          cnt_d  = cnt_n;
          rd_en  = 1'b1;
          rd_ptr = cnt_n - 1'b1;
        end else if (out_space) begin
          emit      = 1'b1;
          emit_set  = acc_n;
          emit_rank = rank_q;
          emit_last = last_q;
          emit_ovf  = stk_full;
          wr_en     = ~stk_full;
          wr_ptr    = cnt_n;
          wr_data   = {prune_mode_i ? set_q : acc_n, rank_q};
          cnt_d     = last_q ? '0 : (cnt_n + {{(CntW-1){1'b0}}, ~stk_full});
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= emit | (out_valid_q & ~pop);
    end
  end

  // Hold the element under work
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (latch) begin
      set_q  <= in_set_i;
      rank_q <= in_rank_i;
      last_q <= in_last_i;
    end
  end

  // Stack memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr[IdxW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_ptr[IdxW-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_set_o  <= emit_set;
      out_rank_o <= emit_rank;
      out_last_o <= emit_last;
      overflow_o <= emit_ovf;
    end
  end

endmodule

`default_nettype wire

@@ sv/ranked_slice_prune_unprune.sv @@
// Top level of the ranked slice prune/unprune converter.
// Converts a ranked slice between its plain and subtree-merged forms, one element per beat,
// using a stack of (set, rank) pairs that empties after the element marked last. Elements
// enter through a two-entry queue (push/full) and results leave through a result register
// (empty/pop), one result per element in order. An element that finds the stack empty is
// pushed and emitted straight from the idle state; otherwise the stack engine reads the top
// entry and pops entries while they rank higher, since the stack memory gives one read per
// cycle, and takes no new element until the result is emitted; each entry is removed at most
// once. prune_mode (cfg_we_i/cfg_wdata_i) selects merge (0) or remove (1) and must be written
// only while no element is in flight; the block itself does not enforce this. When the stack
// is full the element is not stored and its result carries overflow_o.
`default_nettype none

module ranked_slice_prune_unprune #(
  parameter int unsigned SetBits    = rspu_pkg::SetBitsDef,
  parameter int unsigned RankBits   = rspu_pkg::RankBitsDef,
  parameter int unsigned StackDepth = rspu_pkg::StackDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [SetBits-1:0]  item_set_i,
  input  wire logic [RankBits-1:0] item_rank_i,
  input  wire logic                item_last_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [SetBits-1:0]       out_set_o,
  output logic [RankBits-1:0]      out_rank_o,
  output logic                     out_last_o,
  output logic                     overflow_o
);

  localparam int unsigned DataW = SetBits + RankBits + 1;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  logic             prune_mode_q;
  logic             q_valid, q_ready;
  logic [DataW-1:0] q_data;
  logic [CntW-1:0]  stk_cnt;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prune_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      prune_mode_q <= cfg_wdata_i;
    end
  end

  // Accept element beats
  rspu_front #(
    .DataW (DataW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .wdata_i ({item_set_i, item_rank_i, item_last_i}),
    .valid_o (q_valid),
    .rdata_o (q_data),
    .ready_i (q_ready)
  );

  // Run the stack and emit results
  rspu_back #(
    .SetBits    (SetBits),
    .RankBits   (RankBits),
    .StackDepth (StackDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prune_mode_i (prune_mode_q),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_set_i     (q_data[DataW-1:RankBits+1]),
    .in_rank_i    (q_data[RankBits:1]),
    .in_last_i    (q_data[0]),
    .empty        (empty),
    .pop          (pop),
    .out_set_o    (out_set_o),
    .out_rank_o   (out_rank_o),
    .out_last_o   (out_last_o),
    .overflow_o   (overflow_o),
    .stk_cnt_o    (stk_cnt)
  );

  // Stack fill never passes its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cnt <= CntW'(StackDepth))
    else $error("stack count above depth");

  // A freshly loaded last result leaves an empty stack
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ($past(empty) || $past(pop)) && out_last_o) |-> (stk_cnt == '0))
    else $error("stack not emptied after last element");

  // A freshly loaded overflow result comes from a full stack
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ($past(empty) || $past(pop)) && overflow_o && !out_last_o)
      |-> (stk_cnt == CntW'(StackDepth)))
    else $error("overflow flagged without a full stack");

endmodule

`default_nettype wire

@@ verif/ranked_slice_prune_unprune_test.sv @@
// Self-checking testbench for the ranked slice prune/unprune converter.
module ranked_slice_prune_unprune_test;
  import rspu_pkg::*;

  localparam int unsigned SB = SetBitsDef;
  localparam int unsigned RB = RankBitsDef;
  localparam int unsigned SD = StackDepthDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PrintCap = 100;

  typedef struct packed {
    logic [SB-1:0] set;
    logic [RB-1:0] rank;
    logic          last;
    logic          ovf;
  } conv_result_t;

  // Slice converter predictor and store of pending results
  class slice_scoreboard;
    logic [SB-1:0] set_stack [SD];
    logic [RB-1:0] rank_stack [SD];
    int unsigned   fill;
    bit            prune;
    conv_result_t  pending_results [$];
    int unsigned   mismatch_count;

    function new();
      fill = 0;
      prune = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_mode(bit m);
      prune = m;
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= PrintCap) $display("MISMATCH: %s", msg);
    endtask

    // Pop every deeper-ranked entry, merge or clear its set, then push if there is room
    function void note_input(logic [SB-1:0] set, logic [RB-1:0] rank, logic last);
      conv_result_t r;
      logic [SB-1:0] acc;
      acc = set;
      while (fill > 0 && rank < rank_stack[fill-1]) begin
        if (prune) acc &= ~set_stack[fill-1];
        else acc |= set_stack[fill-1];
        fill--;
      end
      r.ovf = 1'b0;
      if (fill < SD) begin
        set_stack[fill] = prune ? set : acc;
        rank_stack[fill] = rank;
        fill++;
      end else begin
        r.ovf = 1'b1;
      end
      if (last) fill = 0;
      r.set = acc;
      r.rank = rank;
      r.last = last;
      pending_results = {pending_results, r};
    endfunction

    task check_result(logic [SB-1:0] set, logic [RB-1:0] rank, logic last, logic ovf);
      conv_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result set=%h rank=%0d with nothing pending", set, rank));
      end else begin
        e = pending_results.pop_front();
        if (set !== e.set) report($sformatf("out_set %h, want %h", set, e.set));
        if (rank !== e.rank) report($sformatf("out_rank %0d, want %0d", rank, e.rank));
        if (last !== e.last) report($sformatf("out_last %b, want %b", last, e.last));
        if (ovf !== e.ovf) report($sformatf("overflow %b, want %b", ovf, e.ovf));
      end
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic          cfg_wdata_i;
  logic          push;
  logic          full;
  logic [SB-1:0] item_set_i;
  logic [RB-1:0] item_rank_i;
  logic          item_last_i;
  logic          empty;
  logic          pop;
  logic [SB-1:0] out_set_o;
  logic [RB-1:0] out_rank_o;
  logic          out_last_o;
  logic          overflow_o;

  slice_scoreboard sb;
  int unsigned     sent_items;
  int unsigned     cycle_count;
  bit              no_idle;

  ranked_slice_prune_unprune dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_set_i  (item_set_i),
    .item_rank_i (item_rank_i),
    .item_last_i (item_last_i),
    .empty       (empty),
    .pop         (pop),
    .out_set_o   (out_set_o),
    .out_rank_o  (out_rank_o),
    .out_last_o  (out_last_o),
    .overflow_o  (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mix dense, one-hot and sparse sets
  function automatic logic [SB-1:0] pick_set();
    logic [SB-1:0] s;
    case ($urandom_range(3))
      0: s = SB'(1) << $urandom_range(SB-1);
      1: s = $urandom & $urandom;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // Present one element and hold it until the beat is taken
  task automatic drive_element(logic [SB-1:0] set, logic [RB-1:0] rank, logic last);
    int unsigned gap;
    if (!no_idle && $urandom_range(99) < 3) begin
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i) push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    item_set_i <= set;
    item_rank_i <= rank;
    item_last_i <= last;
    do @(posedge clk_i); while (full);
    sb.note_input(set, rank, last);
    sent_items++;
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write prune_mode while the block is idle
  task automatic write_mode(bit m);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic directed_slices();
    // equal ranks, multi-entry pops, lone element, full unwind
    drive_element('0, '0, 1'b0);
    drive_element('1, '1, 1'b0);
    drive_element(32'h0000_00F0, '1, 1'b0);
    drive_element(32'h0F00_0001, 8'd10, 1'b0);
    drive_element(32'h8000_0000, 8'd10, 1'b1);
    drive_element(32'hA5A5_A5A5, 8'd128, 1'b1);
    drive_element(32'hFFFF_0000, 8'd1, 1'b0);
    drive_element(32'h0000_FFFF, 8'd2, 1'b0);
    drive_element(32'h1234_5678, 8'd0, 1'b1);
    @(negedge clk_i) push <= 1'b0;
    wait_drained();
  endtask

  task automatic run_phase(bit m, int unsigned count, bit calm);
    int unsigned start;
    int unsigned len;
    int unsigned kind;
    int unsigned rank;
    int unsigned hi;
    logic [8:0] r;
    bit open;
    write_mode(m);
    no_idle = calm;
    start = sent_items;
    open = 1'b0;
    while (sent_items - start < count) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        // Long climbing slice that can fill the stack and overflow
        len = $urandom_range(SD + 1, SD + 8);
        rank = $urandom_range(40);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(15) == 0) rank = $urandom_range(rank);
          else rank = (rank + $urandom_range(3) > 255) ? 255 : rank + $urandom_range(3);
          drive_element(pick_set(), (i == len - 1) ? RB'($urandom) : RB'(rank),
                        i == len - 1);
        end
        open = 1'b0;
      end else if (kind < 18) begin
        // Lone element with a random last marker
        r = 9'($urandom);
        drive_element(pick_set(), r[7:0], r[8]);
        open = !r[8];
      end else begin
        len = $urandom_range(1, 12);
        hi = $urandom_range(1) ? 255 : 3;
        for (int unsigned i = 0; i < len; i++)
          drive_element(pick_set(), RB'($urandom_range(hi)), i == len - 1);
        open = 1'b0;
      end
    end
    if (open) drive_element(pick_set(), RB'($urandom), 1'b1);
    @(negedge clk_i) push <= 1'b0;
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Result side: take beats, stalling now and then
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!no_idle && $urandom_range(99) < 3) begin
        stall_left = $urandom_range(2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_set_o, out_rank_o, out_last_o, overflow_o);
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    item_set_i = '0;
    item_rank_i = '0;
    item_last_i = 1'b0;
    sent_items = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    write_mode(1'b0);
    directed_slices();
    write_mode(1'b1);
    directed_slices();

    run_phase(1'b0, 170, 1'b0);
    run_phase(1'b1, 170, 1'b0);
    run_phase(1'b1, 170, 1'b1);
    run_phase(1'b0, 170, 1'b0);
    run_phase(1'b1, 170, 1'b0);
    run_phase(1'b0, 170, 1'b0);

    repeat (10) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
